// ----- rtl/core/tes_pkg.sv -----
`timescale 1ns / 1ps
package tes_pkg;

    localparam int NODEW = 12;    // node number width
    localparam int DOFW  = 13;    // degree-of-freedom width
    localparam int CW    = 33;    // coordinate difference width
    localparam int PW    = 64;    // kept width of a difference product
    localparam int DW    = 32;    // material coefficient width
    localparam int TW    = 96;    // product times coefficient
    localparam int SW    = 98;    // signed sum of two terms
    localparam int DENW  = 66;    // 2*|det|
    localparam int NUMW  = 105;   // |numerator| after the Q shift
    localparam int VALW  = 64;    // entry value width
    localparam int IDXW  = 2;     // register index width

    // register indexes
    localparam logic [IDXW-1:0] REG_D_NORMAL = 2'd0;
    localparam logic [IDXW-1:0] REG_D_CROSS  = 2'd1;
    localparam logic [IDXW-1:0] REG_D_SHEAR  = 2'd2;

    localparam logic [DW-1:0] D_NORMAL_RST = 32'd281319;
    localparam logic [DW-1:0] D_CROSS_RST  = 32'd84396;
    localparam logic [DW-1:0] D_SHEAR_RST  = 32'd98462;

    // one classified triangle, as it waits between front and back
    typedef struct packed {
        logic [2:0][NODEW-1:0] node;
        logic [2:0]            b_neg;
        logic [2:0][CW-1:0]    b_mag;
        logic [2:0]            c_neg;
        logic [2:0][CW-1:0]    c_mag;
        logic [DENW-1:0]       den;
        logic                  degen;
    } tri_t;

    // tags that travel with an entry through the back pipeline
    typedef struct packed {
        logic [DOFW-1:0] row_dof;
        logic [DOFW-1:0] col_dof;
        logic            last;
        logic            degen;
    } tag_t;

    typedef struct packed {
        tag_t            tag;
        logic [VALW-1:0] value;
    } res_t;

    // signed difference of two 32-bit coordinates
    function automatic logic signed [CW-1:0] sdiff(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        sdiff = $signed({a[31], a}) - $signed({b[31], b});
    endfunction

    // magnitude of a 33-bit signed value
    function automatic logic [CW-1:0] mag33(input logic signed [CW-1:0] v);
        mag33 = v[CW-1] ? (~v + 33'd1) : v;
    endfunction

endpackage

// ----- rtl/core/tes_fifo.sv -----
`timescale 1ns / 1ps
module tes_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0]    wp_reg, rp_reg;
    logic [NW-1:0]    cnt_reg;
    logic             do_wr, do_rd;

    assign full    = (cnt_reg == NW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rp_reg];

    // advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // hold written data
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

// ----- rtl/core/tes_front.sv -----
`timescale 1ns / 1ps
module tes_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [tes_pkg::NODEW-1:0]   node_a,
    input  logic [tes_pkg::NODEW-1:0]   node_b,
    input  logic [tes_pkg::NODEW-1:0]   node_c,
    input  logic signed [31:0]          xa,
    input  logic signed [31:0]          ya,
    input  logic signed [31:0]          xb,
    input  logic signed [31:0]          yb,
    input  logic signed [31:0]          xc,
    input  logic signed [31:0]          yc,
    output logic                        q_push,
    output tes_pkg::tri_t               q_data,
    input  logic                        q_full
);
    import tes_pkg::*;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    tri_t t1_reg, t2_reg, t3_reg, t4_reg;
    tri_t t4_next;
    logic [PW-1:0] p1_reg, p2_reg;
    logic          s1_reg, s2_reg;
    logic signed [DENW:0] det_reg;

    logic signed [CW-1:0] bd [3];
    logic signed [CW-1:0] cd [3];
    logic [2*CW-1:0]      prod1, prod2;
    logic signed [DENW:0] sv1, sv2;
    logic [DENW:0]        det_abs;

    assign adv    = !q_full;
    assign full   = q_full;
    assign q_push = v4_reg && adv;
    assign q_data = t4_reg;

    // edge vectors of the strain matrix
    assign bd[0] = sdiff(yb, yc);
    assign bd[1] = sdiff(yc, ya);
    assign bd[2] = sdiff(ya, yb);
    assign cd[0] = sdiff(xc, xb);
    assign cd[1] = sdiff(xa, xc);
    assign cd[2] = sdiff(xb, xa);

    // cross products for the doubled area
    assign prod1 = {{CW{1'b0}}, t1_reg.c_mag[2]} * {{CW{1'b0}}, t1_reg.b_mag[1]};
    assign prod2 = {{CW{1'b0}}, t1_reg.c_mag[1]} * {{CW{1'b0}}, t1_reg.b_mag[2]};
    assign sv1 = s1_reg ? -$signed({3'b0, p1_reg}) : $signed({3'b0, p1_reg});
    assign sv2 = s2_reg ? -$signed({3'b0, p2_reg}) : $signed({3'b0, p2_reg});
    assign det_abs = det_reg[DENW] ? (~det_reg + 1'b1) : det_reg;

    // attach the divisor and the zero-area flag
    always_comb
    begin
        t4_next       = t3_reg;
        t4_next.den   = {det_abs[DENW-2:0], 1'b0};
        t4_next.degen = (det_reg == '0);
    end

    // advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= push;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // advance stage payloads
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg.node  <= {node_c, node_b, node_a};
            t1_reg.den   <= '0;
            t1_reg.degen <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                t1_reg.b_neg[k] <= bd[k][CW-1];
                t1_reg.b_mag[k] <= mag33(bd[k]);
                t1_reg.c_neg[k] <= cd[k][CW-1];
                t1_reg.c_mag[k] <= mag33(cd[k]);
            end
            t2_reg  <= t1_reg;
            p1_reg  <= prod1[PW-1:0];
            p2_reg  <= prod2[PW-1:0];
            s1_reg  <= t1_reg.c_neg[2] ^ t1_reg.b_neg[1];
            s2_reg  <= t1_reg.c_neg[1] ^ t1_reg.b_neg[2];
            t3_reg  <= t2_reg;
            det_reg <= sv1 - sv2;
            t4_reg  <= t4_next;
        end
    end

endmodule

// ----- rtl/core/tes_back.sv -----
`timescale 1ns / 1ps
module tes_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_empty,
    input  tes_pkg::tri_t           q_data,
    output logic                    q_pop,
    input  logic [tes_pkg::DW-1:0]  d_normal,
    input  logic [tes_pkg::DW-1:0]  d_cross,
    input  logic [tes_pkg::DW-1:0]  d_shear,
    input  logic                    out_full,
    output logic                    o_push,
    output tes_pkg::res_t           o_data
);
    import tes_pkg::*;

    logic adv, take, issue_last;
    logic busy_reg;
    logic [2:0] row_reg, col_reg;
    tri_t el_reg;

    // operand select
    logic [1:0]     m, n;
    logic           ai, aj;
    logic [CW-1:0]  u1, v1, u2, v2;
    logic           un1, vn1, un2, vn2;
    logic [DW-1:0]  dsel1, dsel2;
    logic [2*CW-1:0] pr1, pr2;

    // pipeline registers
    logic            sv1_reg, sv2_reg, sv3_reg, sv4_reg, sv5_reg;
    tag_t            tg1_reg, tg2_reg, tg3_reg, tg4_reg, tg5_reg;
    logic [DENW-1:0] dn1_reg, dn2_reg, dn3_reg, dn4_reg, dn5_reg;
    logic [PW-1:0]   p1_reg, p2_reg;
    logic            s1_reg, s2_reg, s1b_reg, s2b_reg, s1c_reg, s2c_reg;
    logic [DW-1:0]   d1_reg, d2_reg;
    logic [63:0]     pl1_reg, ph1_reg, pl2_reg, ph2_reg;
    logic [TW-1:0]   t1_reg, t2_reg;
    logic signed [SW-1:0] sum_reg;
    logic            neg5_reg;
    logic [NUMW-1:0] num5_reg;

    logic signed [SW-1:0] sa, sb;
    logic [SW-1:0]        sum_abs;

    // divider pipeline
    logic            dv_valid [0:NUMW];
    logic [DENW-1:0] dv_rem   [0:NUMW];
    logic [NUMW-1:0] dv_nq    [0:NUMW];
    logic [DENW-1:0] dv_den   [0:NUMW];
    logic            dv_neg   [0:NUMW];
    tag_t            dv_tag   [0:NUMW];

    logic            fin_valid_reg;
    res_t            fin_reg;
    logic [NUMW-1:0] q;
    logic [VALW-1:0] sat;

    assign adv        = !out_full;
    assign issue_last = el_reg.degen || (row_reg == 3'd5 && col_reg == 3'd5);
    assign take       = adv && !q_empty && (!busy_reg || issue_last);
    assign q_pop      = take;
    assign o_push     = adv && fin_valid_reg;
    assign o_data     = fin_reg;

    // step through the 36 entries of the held triangle, or its one degenerate entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else if (adv)
        begin
            if (take)
            begin
                busy_reg <= 1'b1;
                row_reg  <= '0;
                col_reg  <= '0;
            end
            else if (busy_reg && issue_last)
                busy_reg <= 1'b0;
            else if (busy_reg)
            begin
                if (col_reg == 3'd5)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 3'd1;
                end
                else
                    col_reg <= col_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            el_reg <= q_data;
    end

    // pick the two terms of the entry by axis pair
    always_comb
    begin
        m  = row_reg[2:1];
        n  = col_reg[2:1];
        ai = row_reg[0];
        aj = col_reg[0];
        case ({ai, aj})
            2'b00:
            begin
                u1 = el_reg.b_mag[m]; un1 = el_reg.b_neg[m];
                v1 = el_reg.b_mag[n]; vn1 = el_reg.b_neg[n]; dsel1 = d_normal;
                u2 = el_reg.c_mag[m]; un2 = el_reg.c_neg[m];
                v2 = el_reg.c_mag[n]; vn2 = el_reg.c_neg[n]; dsel2 = d_shear;
            end
            2'b01:
            begin
                u1 = el_reg.b_mag[m]; un1 = el_reg.b_neg[m];
                v1 = el_reg.c_mag[n]; vn1 = el_reg.c_neg[n]; dsel1 = d_cross;
                u2 = el_reg.c_mag[m]; un2 = el_reg.c_neg[m];
                v2 = el_reg.b_mag[n]; vn2 = el_reg.b_neg[n]; dsel2 = d_shear;
            end
            2'b10:
            begin
                u1 = el_reg.c_mag[m]; un1 = el_reg.c_neg[m];
                v1 = el_reg.b_mag[n]; vn1 = el_reg.b_neg[n]; dsel1 = d_cross;
                u2 = el_reg.b_mag[m]; un2 = el_reg.b_neg[m];
                v2 = el_reg.c_mag[n]; vn2 = el_reg.c_neg[n]; dsel2 = d_shear;
            end
            default:
            begin
                u1 = el_reg.c_mag[m]; un1 = el_reg.c_neg[m];
                v1 = el_reg.c_mag[n]; vn1 = el_reg.c_neg[n]; dsel1 = d_normal;
                u2 = el_reg.b_mag[m]; un2 = el_reg.b_neg[m];
                v2 = el_reg.b_mag[n]; vn2 = el_reg.b_neg[n]; dsel2 = d_shear;
            end
        endcase
    end

    assign pr1 = {{CW{1'b0}}, u1} * {{CW{1'b0}}, v1};
    assign pr2 = {{CW{1'b0}}, u2} * {{CW{1'b0}}, v2};

    // combine partial products and apply signs
    assign sa = s1c_reg ? -$signed({2'b0, t1_reg}) : $signed({2'b0, t1_reg});
    assign sb = s2c_reg ? -$signed({2'b0, t2_reg}) : $signed({2'b0, t2_reg});
    assign sum_abs = sum_reg[SW-1] ? (~sum_reg + 1'b1) : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sv1_reg <= 1'b0;
            sv2_reg <= 1'b0;
            sv3_reg <= 1'b0;
            sv4_reg <= 1'b0;
            sv5_reg <= 1'b0;
        end
        else if (adv)
        begin
            sv1_reg <= busy_reg;
            sv2_reg <= sv1_reg;
            sv3_reg <= sv2_reg;
            sv4_reg <= sv3_reg;
            sv5_reg <= sv4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // products of edge terms
            p1_reg  <= pr1[PW-1:0];
            p2_reg  <= pr2[PW-1:0];
            s1_reg  <= un1 ^ vn1;
            s2_reg  <= un2 ^ vn2;
            d1_reg  <= dsel1;
            d2_reg  <= dsel2;
            tg1_reg.row_dof <= el_reg.degen ? '0 : {el_reg.node[m], ai};
            tg1_reg.col_dof <= el_reg.degen ? '0 : {el_reg.node[n], aj};
            tg1_reg.last    <= issue_last;
            tg1_reg.degen   <= el_reg.degen;
            dn1_reg <= el_reg.den;
            // scale by the material coefficient in halves
            pl1_reg <= {32'b0, p1_reg[31:0]} * {32'b0, d1_reg};
            ph1_reg <= {32'b0, p1_reg[63:32]} * {32'b0, d1_reg};
            pl2_reg <= {32'b0, p2_reg[31:0]} * {32'b0, d2_reg};
            ph2_reg <= {32'b0, p2_reg[63:32]} * {32'b0, d2_reg};
            s1b_reg <= s1_reg;
            s2b_reg <= s2_reg;
            tg2_reg <= tg1_reg;
            dn2_reg <= dn1_reg;
            // join halves
            t1_reg  <= {ph1_reg, 32'b0} + {32'b0, pl1_reg};
            t2_reg  <= {ph2_reg, 32'b0} + {32'b0, pl2_reg};
            s1c_reg <= s1b_reg;
            s2c_reg <= s2b_reg;
            tg3_reg <= tg2_reg;
            dn3_reg <= dn2_reg;
            // signed sum
            sum_reg <= sa + sb;
            tg4_reg <= tg3_reg;
            dn4_reg <= dn3_reg;
            // magnitude and Q shift
            neg5_reg <= sum_reg[SW-1];
            num5_reg <= {sum_abs[SW-2:0], 8'b0};
            tg5_reg  <= tg4_reg;
            dn5_reg  <= dn4_reg;
        end
    end

    // feed the divider
    assign dv_valid[0] = sv5_reg;
    assign dv_rem[0]   = '0;
    assign dv_nq[0]    = num5_reg;
    assign dv_den[0]   = dn5_reg;
    assign dv_neg[0]   = neg5_reg;
    assign dv_tag[0]   = tg5_reg;

    // one quotient bit per stage
    for (genvar k = 0; k < NUMW; k++)
    begin : g_div
        logic [DENW:0] trial, diff;
        logic          ge;
        assign trial = {dv_rem[k], dv_nq[k][NUMW-1]};
        assign ge    = (trial >= {1'b0, dv_den[k]});
        assign diff  = trial - {1'b0, dv_den[k]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid[k+1] <= 1'b0;
            else if (adv)
                dv_valid[k+1] <= dv_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem[k+1] <= ge ? diff[DENW-1:0] : trial[DENW-1:0];
                dv_nq[k+1]  <= {dv_nq[k][NUMW-2:0], ge};
                dv_den[k+1] <= dv_den[k];
                dv_neg[k+1] <= dv_neg[k];
                dv_tag[k+1] <= dv_tag[k];
            end
        end
    end

    // saturate to the signed 64-bit range
    assign q = dv_nq[NUMW];
    always_comb
    begin
        if (!dv_neg[NUMW])
        begin
            if (q[NUMW-1:63] != '0)
                sat = {1'b0, {(VALW-1){1'b1}}};
            else
                sat = q[VALW-1:0];
        end
        else
        begin
            if (q[NUMW-1:64] != '0 || (q[63] && q[62:0] != '0))
                sat = {1'b1, {(VALW-1){1'b0}}};
            else
                sat = ~q[VALW-1:0] + 64'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_valid_reg <= 1'b0;
        else if (adv)
            fin_valid_reg <= dv_valid[NUMW];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fin_reg.tag   <= dv_tag[NUMW];
            fin_reg.value <= dv_tag[NUMW].degen ? '0 : sat;
        end
    end

endmodule

// ----- rtl/core/triangle_element_stiffness.sv -----
`timescale 1ns / 1ps
// Plane-stress constant-strain triangle stiffness generator.
// Input side is a queue: present one triangle (three node numbers and
// six Q12.20 coordinates) with push; it transfers when push is high and
// full is low. Result side is a queue too: while empty is low the oldest
// entry (row_dof, col_dof, entry_value, last, degenerate) is on the ports,
// and it transfers when pop is high.
// Each triangle yields 36 entries in row-major order, last set on the
// 36th; a zero-area triangle yields one entry with degenerate and last set.
// Throughput: one entry per cycle while the result queue is not full,
// set by the single issue port of the back pipeline. Each triangle passes
// the front stages, multiply stages and the 105-stage restoring divider.
// Material coefficients d_normal, d_cross, d_shear are written through
// wr_en / wr_index / wr_data; the user writes them only while the block
// is idle, which the block itself does not enforce.
// Reset clears all pipelines and queues and loads the default coefficients.
// When the receiver stalls and the result queue fills, the back pipeline
// freezes; the front keeps accepting until the middle queue fills.
module triangle_element_stiffness (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [tes_pkg::NODEW-1:0]   node_a,
    input  logic [tes_pkg::NODEW-1:0]   node_b,
    input  logic [tes_pkg::NODEW-1:0]   node_c,
    input  logic signed [31:0]          xa,
    input  logic signed [31:0]          ya,
    input  logic signed [31:0]          xb,
    input  logic signed [31:0]          yb,
    input  logic signed [31:0]          xc,
    input  logic signed [31:0]          yc,
    output logic                        empty,
    input  logic                        pop,
    output logic [tes_pkg::DOFW-1:0]    row_dof,
    output logic [tes_pkg::DOFW-1:0]    col_dof,
    output logic signed [63:0]          entry_value,
    output logic                        last,
    output logic                        degenerate,
    input  logic                        wr_en,
    input  logic [tes_pkg::IDXW-1:0]    wr_index,
    input  logic [tes_pkg::DW-1:0]      wr_data
);
    import tes_pkg::*;

    logic [DW-1:0] d_normal_reg, d_cross_reg, d_shear_reg;
    logic  mq_push, mq_full, mq_pop, mq_empty;
    tri_t  mq_wdata, mq_rdata;
    logic  oq_push, oq_full;
    res_t  oq_wdata, oq_rdata;

    // hold material coefficients
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_normal_reg <= D_NORMAL_RST;
            d_cross_reg  <= D_CROSS_RST;
            d_shear_reg  <= D_SHEAR_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_D_NORMAL: d_normal_reg <= wr_data;
                REG_D_CROSS:  d_cross_reg  <= wr_data;
                REG_D_SHEAR:  d_shear_reg  <= wr_data;
                default:      ;
            endcase
        end
    end

    tes_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .node_a (node_a),
        .node_b (node_b),
        .node_c (node_c),
        .xa     (xa),
        .ya     (ya),
        .xb     (xb),
        .yb     (yb),
        .xc     (xc),
        .yc     (yc),
        .q_push (mq_push),
        .q_data (mq_wdata),
        .q_full (mq_full)
    );

    tes_fifo #(.WIDTH($bits(tri_t)), .DEPTH(2)) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mq_push),
        .wr_data (mq_wdata),
        .full    (mq_full),
        .rd_en   (mq_pop),
        .rd_data (mq_rdata),
        .empty   (mq_empty)
    );

    tes_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (mq_empty),
        .q_data   (mq_rdata),
        .q_pop    (mq_pop),
        .d_normal (d_normal_reg),
        .d_cross  (d_cross_reg),
        .d_shear  (d_shear_reg),
        .out_full (oq_full),
        .o_push   (oq_push),
        .o_data   (oq_wdata)
    );

    tes_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (oq_push),
        .wr_data (oq_wdata),
        .full    (oq_full),
        .rd_en   (pop),
        .rd_data (oq_rdata),
        .empty   (empty)
    );

    // drive result ports from the queue head
    assign row_dof     = oq_rdata.tag.row_dof;
    assign col_dof     = oq_rdata.tag.col_dof;
    assign last        = oq_rdata.tag.last;
    assign degenerate  = oq_rdata.tag.degen;
    assign entry_value = oq_rdata.value;

endmodule
